/* hw/rtl/lup_pkg.sv */
// Shared types, constants and helpers for the line upsampler.
package lup_pkg;

  localparam int MAG_BITS       = 5;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int MAX_MAG_DEF    = 16;

  typedef enum logic [0:0] {
    REG_MAG_FACTOR    = 1'b0,
    REG_INTERP_ENABLE = 1'b1
  } lup_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } lup_state_t;

  typedef enum logic [1:0] {
    K_PIX,
    K_HELD,
    K_INTERP
  } lup_kind_t;

  typedef struct packed {
    logic      load;
    logic      take_held;
    logic      emit;
    lup_kind_t kind;
    logic      row_end;
    logic      last;
    logic      commit;
  } lup_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } lup_status_t;

  function automatic logic [MAG_BITS-1:0] eff_factor(input logic [MAG_BITS-1:0] mag,
                                                     input int max_mag);
    logic [MAG_BITS-1:0] f;
    f = mag;
    if (f == '0) begin
      f = MAG_BITS'(1);
    end
    if (int'(f) > max_mag) begin
      f = MAG_BITS'(max_mag);
    end
    return f;
  endfunction

endpackage

/* hw/rtl/lup_ctrl.sv */
// Controller state machine: sequences load, division and item emission.
module lup_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [lup_pkg::MAG_BITS-1:0] fac,
  input  logic                         interp_en,
  input  logic                         in_tvalid,
  input  logic                         in_tlast,
  output logic                         in_tready,
  input  lup_pkg::lup_status_t         status,
  output lup_pkg::lup_cmd_t            cmd
);
  import lup_pkg::*;

  lup_state_t          state_r, state_nxt;
  logic [MAG_BITS-1:0] k_r, k_nxt;
  logic                rend_r, rend_nxt;
  logic                interp_r, interp_nxt;
  logic                have_held_r, have_held_nxt;
  logic                acc;
  logic                at_last_step;
  logic                at_end;
  logic                is_final;

  assign acc          = in_tvalid && (state_r == S_IDLE);
  assign at_last_step = (k_r == fac - MAG_BITS'(1));
  assign at_end       = (k_r == fac);
  assign is_final     = interp_r ? (rend_r ? at_end : at_last_step) : at_last_step;

  // next state
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    rend_nxt      = rend_r;
    interp_nxt    = interp_r;
    have_held_nxt = have_held_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          rend_nxt   = in_tlast;
          interp_nxt = interp_en;
          k_nxt      = '0;
          if (!interp_en) begin
            have_held_nxt = 1'b0;
            state_nxt     = S_EMIT;
          end else if (have_held_r) begin
            state_nxt = S_DIV;
          end else if (in_tlast) begin
            k_nxt     = fac;
            state_nxt = S_EMIT;
          end else begin
            have_held_nxt = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          if (is_final) begin
            state_nxt = S_IDLE;
            if (interp_r) begin
              have_held_nxt = !rend_r;
            end
          end else begin
            k_nxt = k_r + MAG_BITS'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_tready     = (state_r == S_IDLE);
    cmd.load      = acc;
    cmd.take_held = acc && interp_en && !have_held_r;
    cmd.emit      = 1'b0;
    cmd.kind      = K_PIX;
    cmd.row_end   = 1'b0;
    cmd.last      = 1'b0;
    cmd.commit    = 1'b0;
    case (state_r)
      S_EMIT: begin
        cmd.emit = status.out_free;
        cmd.last = is_final;
        if (interp_r) begin
          cmd.row_end = at_end;
          if (k_r == '0) begin
            cmd.kind = K_HELD;
          end else if (at_end) begin
            cmd.kind = K_PIX;
          end else begin
            cmd.kind = K_INTERP;
          end
          cmd.commit = status.out_free && is_final;
        end else begin
          cmd.row_end = rend_r && at_last_step;
        end
      end
      default: begin
        cmd.emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      rend_r      <= 1'b0;
      interp_r    <= 1'b0;
      have_held_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      rend_r      <= rend_nxt;
      interp_r    <= interp_nxt;
      have_held_r <= have_held_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_emit_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> !cmd.emit)
    else $error("item emitted while division runs");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> (state_r == S_IDLE))
    else $error("controller did not return to idle after last item");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (interp_r ? (k_r <= fac) : (k_r < fac)))
    else $error("step counter ran past factor");

  a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(state_r) == S_IDLE && state_r == S_DIV) |-> status.div_busy)
    else $error("division not started on entry");
`endif

endmodule

/* hw/rtl/lup_dpath.sv */
// Datapath: pixel registers, serial divider, interpolation stepper, output register.
module lup_dpath #(
  parameter int PIXEL_BITS = lup_pkg::PIXEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [lup_pkg::MAG_BITS-1:0] fac,
  input  logic [PIXEL_BITS-1:0]        in_pixel,
  input  lup_pkg::lup_cmd_t            cmd,
  output lup_pkg::lup_status_t         status,
  input  logic                         out_tready,
  output logic                         out_valid,
  output logic [PIXEL_BITS-1:0]        out_pixel,
  output logic                         out_row_end,
  output logic                         out_last
);
  import lup_pkg::*;

  localparam int CNT_W = $clog2(PIXEL_BITS + 2);

  logic [PIXEL_BITS-1:0] held_r, new_r;
  logic                  neg_r;
  logic [PIXEL_BITS-1:0] dvd_r;
  logic [MAG_BITS-1:0]   rem_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [PIXEL_BITS-1:0] qd_r;
  logic [MAG_BITS-1:0]   rd_r;
  logic [PIXEL_BITS-1:0] val_r;
  logic [MAG_BITS-1:0]   racc_r;
  logic                  out_valid_r;
  logic [PIXEL_BITS-1:0] out_pix_r;
  logic                  out_rend_r, out_last_r;

  logic [MAG_BITS:0]     fac_x;
  logic [MAG_BITS:0]     trial;
  logic                  trial_ge;
  logic                  rem_nz;
  logic [MAG_BITS:0]     rsum;
  logic                  rcarry;
  logic [PIXEL_BITS-1:0] val_nxt;
  logic [PIXEL_BITS-1:0] absd;
  logic                  in_lt;
  logic [PIXEL_BITS-1:0] emit_pix;

  assign fac_x    = {1'b0, fac};
  assign trial    = {rem_r, dvd_r[PIXEL_BITS-1]};
  assign trial_ge = (trial >= fac_x);
  assign rem_nz   = (rem_r != '0);
  assign rsum     = {1'b0, racc_r} + {1'b0, rd_r};
  assign rcarry   = (rsum >= fac_x);
  assign val_nxt  = val_r + qd_r + PIXEL_BITS'(rcarry);
  assign in_lt    = (in_pixel < held_r);
  assign absd     = in_lt ? (held_r - in_pixel) : (in_pixel - held_r);

  always_comb begin
    case (cmd.kind)
      K_HELD:   emit_pix = held_r;
      K_INTERP: emit_pix = val_nxt;
      default:  emit_pix = new_r;
    endcase
  end

  assign status.div_busy = (cnt_r != '0);
  assign status.out_free = !out_valid_r || out_tready;

  // pixel registers and serial divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (cmd.take_held) begin
        held_r <= in_pixel;
      end else if (cmd.commit) begin
        held_r <= new_r;
      end
      if (cmd.load) begin
        cnt_r <= CNT_W'(PIXEL_BITS + 1);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      new_r <= in_pixel;
      neg_r <= in_lt;
      dvd_r <= absd;
      rem_r <= '0;
    end else if (cnt_r > CNT_W'(1)) begin
      rem_r <= trial_ge ? MAG_BITS'(trial - fac_x) : MAG_BITS'(trial);
      dvd_r <= {dvd_r[PIXEL_BITS-2:0], trial_ge};
    end else if (cnt_r == CNT_W'(1)) begin
      // floor toward minus infinity for a falling ramp
      if (neg_r) begin
        qd_r <= ~dvd_r + PIXEL_BITS'(!rem_nz);
        rd_r <= rem_nz ? (fac - rem_r) : '0;
      end else begin
        qd_r <= dvd_r;
        rd_r <= rem_r;
      end
    end
  end

  // interpolation stepper
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.kind == K_HELD) begin
        val_r  <= held_r;
        racc_r <= '0;
      end else if (cmd.kind == K_INTERP) begin
        val_r  <= val_nxt;
        racc_r <= rcarry ? MAG_BITS'(rsum - fac_x) : MAG_BITS'(rsum);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pix_r  <= emit_pix;
      out_rend_r <= cmd.row_end;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pixel   = out_pix_r;
  assign out_row_end = out_rend_r;
  assign out_last    = out_last_r;

endmodule

/* hw/rtl/line_upsampler_replicate_linear.sv */
// Line upsampler top level: configuration registers, controller and datapath.
//
// Magnifies a row of unsigned pixels by an integer factor f (mag_factor, 0 acts as 1,
// clamped to MAX_MAG). Replicate mode: each item gives f output items. Interpolate
// mode: the first pixel of a row is only held, unless it also ends the row, when it is
// emitted once; each later pixel first runs a bit-serial divider of (new - held) by f,
// then emits the held pixel and f - 1 interpolated items (plus the pixel itself at row
// end), one per cycle while the output register is free. The output register lets the
// next item be accepted while the final result waits; out_tready stalls hold emission.
module line_upsampler_replicate_linear #(
  parameter int PIXEL_BITS = lup_pkg::PIXEL_BITS_DEF,
  parameter int MAX_MAG    = lup_pkg::MAX_MAG_DEF,
  parameter int TDATA_W    = ((PIXEL_BITS + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [lup_pkg::MAG_BITS-1:0] cfg_wdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [TDATA_W-1:0]           in_tdata,   // in_pixel
  input  logic                         in_tlast,   // row_end
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [TDATA_W-1:0]           out_tdata,  // out_pixel
  output logic                         out_tlast,  // out_row_end
  output logic                         out_tuser   // last
);
  import lup_pkg::*;

  logic [MAG_BITS-1:0]   mag_r;
  logic                  interp_r;
  logic [MAG_BITS-1:0]   fac;
  lup_cmd_t              cmd;
  lup_status_t           status;
  logic [PIXEL_BITS-1:0] out_pixel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r    <= MAG_BITS'(1);
      interp_r <= 1'b0;
    end else if (cfg_we) begin
      case (lup_reg_t'(cfg_index))
        REG_MAG_FACTOR:    mag_r    <= cfg_wdata;
        REG_INTERP_ENABLE: interp_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign fac = eff_factor(mag_r, MAX_MAG);

  lup_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fac       (fac),
    .interp_en (interp_r),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  lup_dpath #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .fac         (fac),
    .in_pixel    (in_tdata[PIXEL_BITS-1:0]),
    .cmd         (cmd),
    .status      (status),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .out_pixel   (out_pixel),
    .out_row_end (out_tlast),
    .out_last    (out_tuser)
  );

  assign out_tdata = TDATA_W'(out_pixel);

endmodule
